[src/kcrd_pkg.sv]
package kcrd_pkg;

  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned MinRecord = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
  localparam logic [31:0] MagicReset = 32'h474C4753;
  localparam logic [32:0] PosMax     = {33{1'b1}};

  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LEN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VERSION  = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
  localparam logic [2:0] ST_SHORT_DATA   = 3'd4;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic [2:0]  record_status;
    logic        end_of_run;
  } out_item_t;

  typedef struct packed {
    logic pay_valid;
    logic st_valid;
  } push_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

[src/kcrd_out_queue.sv]
module kcrd_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kcrd_pkg::push_t      push_i,
  input  kcrd_pkg::out_item_t  pay_i,
  input  kcrd_pkg::out_item_t  st_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kcrd_pkg::out_item_t  out_data_o
);

  kcrd_pkg::out_item_t slot_q [3];
  kcrd_pkg::out_item_t slot_d [3];
  logic [1:0] count_q, count_d;
  logic       pop;
  logic [1:0] base;
  logic [1:0] st_pos;

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[0];
  assign space_o     = (count_q <= 2'd1);
  assign pop         = out_valid_o && out_ready_i;
  assign base        = count_q - {1'b0, pop};
  assign st_pos      = base + {1'b0, push_i.pay_valid};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
    for (int i = 0; i < 3; i++) begin
      if (push_i.pay_valid && base == 2'(i)) begin
        slot_d[i] = pay_i;
      end
      if (push_i.st_valid && st_pos == 2'(i)) begin
        slot_d[i] = st_i;
      end
    end
    count_d = base + {1'b0, push_i.pay_valid} + {1'b0, push_i.st_valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

[src/keyed_crc_record_deframer_top.sv]
// Channel   Direction  Payload                Handshake
// in        input      kcrd_pkg::in_item_t    in_valid_i / in_ready_o
// out       output     kcrd_pkg::out_item_t   out_valid_o / out_ready_i
// cfg       input      index, 64-bit data     cfg_we_i, no wait
//
// One byte per cycle enters while in_ready_o is high; its payload result is registered in the
// output queue. A final byte that also carries payload yields two results, drained one per
// cycle while out_ready_i is high from a three-entry output queue; input is held while it has
// fewer than two free entries. Reset clears record state and loads register defaults.
module keyed_crc_record_deframer_top #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  kcrd_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output kcrd_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [kcrd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [kcrd_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [4:0] MaxLen = 5'(MAX_KEY_BYTES);

  logic [MAX_KEY_BYTES-1:0][7:0] key_q;
  logic [4:0]  key_len_q;
  logic [31:0] magic_q;
  logic [31:0] version_q;

  logic [32:0]    pos_q, pos_d;
  logic [31:0]    hdr_q, hdr_d;
  logic           magic_ok_q, magic_ok_d;
  logic           version_ok_q, version_ok_d;
  logic [31:0]    size_q, size_d;
  logic [KIW-1:0] kidx_q, kidx_d;
  logic [31:0]    crc_q, crc_d;
  logic [31:0]    chk_q, chk_d;

  logic           in_xfer;
  logic           fin;
  logic [7:0]     raw;
  logic           is_hdr;
  logic [32:0]    off;
  logic [7:0]     dec;
  logic [4:0]     len_eff;
  logic [4:0]     kidx_inc;
  logic [KIW-1:0] kidx_nxt;
  logic           in_pay;
  logic           in_chk;
  logic [32:0]    count;
  logic [2:0]     status;
  logic           space;

  kcrd_pkg::push_t     push;
  kcrd_pkg::out_item_t pay_item;
  kcrd_pkg::out_item_t st_item;

  assign in_ready_o = space;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign raw        = in_data_i.data_byte;
  assign fin        = in_data_i.final_byte;

  assign is_hdr   = (pos_q < 33'(kcrd_pkg::HdrBytes));
  assign off      = pos_q - 33'(kcrd_pkg::HdrBytes);
  assign dec      = raw ^ key_q[kidx_q];
  assign len_eff  = (key_len_q == 5'd0) ? 5'd1 : ((key_len_q > MaxLen) ? MaxLen : key_len_q);
  assign kidx_inc = {{(5-KIW){1'b0}}, kidx_q} + 5'd1;
  assign kidx_nxt = (kidx_inc >= len_eff) ? '0 : kidx_inc[KIW-1:0];
  assign in_pay   = !is_hdr && (off < {1'b0, size_q});
  assign in_chk   = !is_hdr && !in_pay && ({1'b0, off} < ({2'b00, size_q} + 34'd4));
  assign count    = (pos_q != kcrd_pkg::PosMax) ? pos_q + 33'd1 : pos_q;

  always_comb begin
    hdr_d        = hdr_q;
    magic_ok_d   = magic_ok_q;
    version_ok_d = version_ok_q;
    size_d       = size_q;
    kidx_d       = kidx_q;
    crc_d        = crc_q;
    chk_d        = chk_q;
    if (is_hdr) begin
      hdr_d = {raw, hdr_q[31:8]};
      if (pos_q == 33'd3) begin
        magic_ok_d = (hdr_d == magic_q);
      end else if (pos_q == 33'd7) begin
        version_ok_d = (hdr_d == version_q);
      end else if (pos_q == 33'd11) begin
        size_d = hdr_d;
      end
    end else begin
      kidx_d = kidx_nxt;
      if (in_pay) begin
        crc_d = kcrd_pkg::crc32_byte(crc_q, dec);
      end else if (in_chk) begin
        chk_d = {dec, chk_q[31:8]};
      end
    end
  end

  always_comb begin
    if (count < 33'(kcrd_pkg::MinRecord)) begin
      status = kcrd_pkg::ST_SHORT_HEADER;
    end else if (!magic_ok_d) begin
      status = kcrd_pkg::ST_BAD_MAGIC;
    end else if (!version_ok_d) begin
      status = kcrd_pkg::ST_BAD_VERSION;
    end else if ({1'b0, count} < (34'(kcrd_pkg::HdrBytes) + {2'b00, size_d} + 34'd4)) begin
      status = kcrd_pkg::ST_SHORT_DATA;
    end else if (~crc_d != chk_d) begin
      status = kcrd_pkg::ST_CRC_MISMATCH;
    end else begin
      status = kcrd_pkg::ST_OK;
    end
  end

  assign pos_d = count;

  assign push.pay_valid = in_xfer && in_pay;
  assign push.st_valid  = in_xfer && fin;

  assign pay_item.result_kind    = kcrd_pkg::KIND_PAYLOAD;
  assign pay_item.payload_byte   = dec;
  assign pay_item.payload_offset = off[31:0];
  assign pay_item.record_status  = kcrd_pkg::ST_OK;
  assign pay_item.end_of_run     = !fin;

  assign st_item.result_kind    = kcrd_pkg::KIND_STATUS;
  assign st_item.payload_byte   = 8'd0;
  assign st_item.payload_offset = 32'd0;
  assign st_item.record_status  = status;
  assign st_item.end_of_run     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      hdr_q        <= '0;
      magic_ok_q   <= 1'b0;
      version_ok_q <= 1'b0;
      size_q       <= '0;
      kidx_q       <= '0;
      crc_q        <= kcrd_pkg::CrcInit;
      chk_q        <= '0;
    end else if (in_xfer) begin
      if (fin) begin
        pos_q        <= '0;
        hdr_q        <= '0;
        magic_ok_q   <= 1'b0;
        version_ok_q <= 1'b0;
        size_q       <= '0;
        kidx_q       <= '0;
        crc_q        <= kcrd_pkg::CrcInit;
        chk_q        <= '0;
      end else begin
        pos_q        <= pos_d;
        hdr_q        <= hdr_d;
        magic_ok_q   <= magic_ok_d;
        version_ok_q <= version_ok_d;
        size_q       <= size_d;
        kidx_q       <= kidx_d;
        crc_q        <= crc_d;
        chk_q        <= chk_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= 5'd1;
      magic_q   <= kcrd_pkg::MagicReset;
      version_q <= 32'd1;
    end else if (cfg_we_i) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if (i < 8 && cfg_idx_i == kcrd_pkg::CFG_KEY_LOW) begin
          key_q[i] <= cfg_wdata_i[(i % 8) * 8 +: 8];
        end
        if (i >= 8 && cfg_idx_i == kcrd_pkg::CFG_KEY_HIGH) begin
          key_q[i] <= cfg_wdata_i[(i % 8) * 8 +: 8];
        end
      end
      case (cfg_idx_i)
        kcrd_pkg::CFG_KEY_LEN: key_len_q <= cfg_wdata_i[4:0];
        kcrd_pkg::CFG_MAGIC:   magic_q   <= cfg_wdata_i[31:0];
        kcrd_pkg::CFG_VERSION: version_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  kcrd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pay_i       (pay_item),
    .st_i        (st_item),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/kcrd_checker.sv]
module kcrd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input kcrd_pkg::in_item_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input kcrd_pkg::out_item_t           out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == kcrd_pkg::KIND_STATUS |->
      out_data_o.end_of_run && out_data_o.payload_byte == 8'd0 &&
      out_data_o.payload_offset == 32'd0)
    else $error("status result malformed");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == kcrd_pkg::KIND_PAYLOAD |->
      out_data_o.record_status == kcrd_pkg::ST_OK)
    else $error("payload result carries a status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.record_status <= kcrd_pkg::ST_CRC_MISMATCH)
    else $error("status code out of range");

  a_final_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.final_byte |=> out_valid_o)
    else $error("final byte left no result");

endmodule

bind keyed_crc_record_deframer_top kcrd_checker u_kcrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/keyed_crc_record_deframer_top_tb.sv]
`timescale 1ns / 100ps

module keyed_crc_record_deframer_top_tb;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 11;
  localparam int RandomBytes  = 800;
  localparam int CalmFrom     = 700;
  localparam int HoldFrom     = 150;
  localparam int HoldCycles   = 80;
  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 20;
  localparam int RecsPerPhase = 6;
  localparam int KeyBytesMax  = 16;

  localparam logic [kcrd_pkg::CfgIdxW-1:0] CFG_UNUSED_FIRST = kcrd_pkg::CFG_VERSION + 3'd1;

  typedef enum int {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_VERSION,
    REC_TRUNCATED,
    REC_BAD_CRC,
    REC_NOISE
  } rec_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
    logic       fixed;
    logic [2:0] status;
  } dir_row_t;

  localparam dir_row_t DirRows [24] = '{
    '{8'h00, 1'b1, 1'b1, kcrd_pkg::ST_SHORT_HEADER},
    '{8'hFF, 1'b1, 1'b1, kcrd_pkg::ST_SHORT_HEADER},
    '{8'h53, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h47, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h4C, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h47, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h01, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'hA5, 1'b1, 1'b1, kcrd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, kcrd_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b1, kcrd_pkg::ST_SHORT_HEADER}
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  kcrd_pkg::in_item_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  kcrd_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [kcrd_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [kcrd_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  logic [63:0] key_lo       = '0;
  logic [63:0] key_hi       = '0;
  logic [4:0]  key_len      = 5'd1;
  logic [31:0] want_magic   = kcrd_pkg::MagicReset;
  logic [31:0] want_version = 32'd1;

  logic [32:0] rec_pos       = '0;
  logic [31:0] hdr_shift     = '0;
  logic        magic_match   = 1'b0;
  logic        version_match = 1'b0;
  logic [31:0] pay_size      = '0;
  logic [3:0]  key_idx       = '0;
  logic [31:0] crc_acc       = kcrd_pkg::CrcInit;
  logic [31:0] crc_stored    = '0;

  kcrd_pkg::out_item_t expected_q [$];
  kcrd_pkg::out_item_t step_q [$];

  int mismatches    = 0;
  int bytes_sent    = 0;
  int records_sent  = 0;
  int results_seen  = 0;
  int status_seen [6] = '{default: 0};
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  keyed_crc_record_deframer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int key_span();
    if (key_len == 5'd0) return 1;
    if (int'(key_len) > KeyBytesMax) return KeyBytesMax;
    return int'(key_len);
  endfunction

  function automatic logic [7:0] key_at(input logic [3:0] idx);
    logic [127:0] key;
    key = {key_hi, key_lo};
    return key[idx*8 +: 8];
  endfunction

  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) c = {1'b0, c[31:1]} ^ kcrd_pkg::CrcPoly;
      else c = {1'b0, c[31:1]};
    end
    return c;
  endfunction

  function automatic void decode_byte(input kcrd_pkg::in_item_t it);
    logic [7:0]          plain;
    logic [63:0]         off;
    logic [63:0]         count;
    logic [2:0]          st;
    kcrd_pkg::out_item_t res;
    bit                  emitted;
    emitted = 1'b0;
    res = '0;
    if (rec_pos < 33'(kcrd_pkg::HdrBytes)) begin
      hdr_shift = {it.data_byte, hdr_shift[31:8]};
      case (rec_pos[3:0])
        4'd3:    magic_match = (hdr_shift == want_magic);
        4'd7:    version_match = (hdr_shift == want_version);
        4'd11:   pay_size = hdr_shift;
        default: ;
      endcase
    end else begin
      off = 64'(rec_pos) - 64'(kcrd_pkg::HdrBytes);
      plain = it.data_byte ^ key_at(key_idx);
      if (int'(key_idx) + 1 >= key_span()) key_idx = 4'd0;
      else key_idx = key_idx + 4'd1;
      if (off < 64'(pay_size)) begin
        crc_acc = crc_next(crc_acc, plain);
        res = '{kcrd_pkg::KIND_PAYLOAD, plain, off[31:0], kcrd_pkg::ST_OK, 1'b0};
        emitted = 1'b1;
      end else if (off < 64'(pay_size) + 64'd4) begin
        crc_stored = {plain, crc_stored[31:8]};
      end
    end
    rec_pos = (rec_pos < kcrd_pkg::PosMax) ? rec_pos + 33'd1 : kcrd_pkg::PosMax;
    count = 64'(rec_pos);
    if (it.final_byte) begin
      if (count < 64'(kcrd_pkg::MinRecord)) st = kcrd_pkg::ST_SHORT_HEADER;
      else if (!magic_match) st = kcrd_pkg::ST_BAD_MAGIC;
      else if (!version_match) st = kcrd_pkg::ST_BAD_VERSION;
      else if (count < 64'(kcrd_pkg::HdrBytes) + 64'(pay_size) + 64'd4)
        st = kcrd_pkg::ST_SHORT_DATA;
      else if (~crc_acc != crc_stored) st = kcrd_pkg::ST_CRC_MISMATCH;
      else st = kcrd_pkg::ST_OK;
      if (emitted) step_q.insert(step_q.size(), res);
      res = '{kcrd_pkg::KIND_STATUS, 8'd0, 32'd0, st, 1'b1};
      step_q.insert(step_q.size(), res);
      rec_pos       = '0;
      hdr_shift     = '0;
      magic_match   = 1'b0;
      version_match = 1'b0;
      pay_size      = '0;
      key_idx       = '0;
      crc_acc       = kcrd_pkg::CrcInit;
      crc_stored    = '0;
    end else if (emitted) begin
      res.end_of_run = 1'b1;
      step_q.insert(step_q.size(), res);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic send_byte(input kcrd_pkg::in_item_t it, input bit fixed,
                           input logic [2:0] fixed_st);
    kcrd_pkg::out_item_t res;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    step_q.delete();
    decode_byte(it);
    if (fixed) begin
      res = '{kcrd_pkg::KIND_STATUS, 8'd0, 32'd0, fixed_st, 1'b1};
      expected_q.insert(expected_q.size(), res);
    end else begin
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    end
    bytes_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kcrd_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      kcrd_pkg::CFG_KEY_LOW:  key_lo = val;
      kcrd_pkg::CFG_KEY_HIGH: key_hi = val;
      kcrd_pkg::CFG_KEY_LEN:  key_len = val[4:0];
      kcrd_pkg::CFG_MAGIC:    want_magic = val[31:0];
      kcrd_pkg::CFG_VERSION:  want_version = val[31:0];
      default:                ;
    endcase
  endtask

  task automatic configure_phase(input int phase);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [31:0] mag;
    logic [31:0] ver;
    lo  = {$urandom, $urandom};
    hi  = {$urandom, $urandom};
    len = 5'($urandom_range(0, 31));
    mag = $urandom;
    ver = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      mag = kcrd_pkg::MagicReset;
      ver = 32'd1;
    end
    case (phase)
      0: begin
        lo = '1; hi = '1; len = 5'd16; mag = '1; ver = '1;
      end
      1: begin
        lo = '0; hi = '0; len = 5'd0; mag = '0; ver = '0;
      end
      2:       len = 5'd31;
      3:       len = 5'd17;
      4:       len = 5'd1;
      default: ;
    endcase
    write_reg(kcrd_pkg::CFG_KEY_LOW, lo);
    write_reg(kcrd_pkg::CFG_KEY_HIGH, hi);
    write_reg(kcrd_pkg::CFG_KEY_LEN, 64'(len));
    write_reg(kcrd_pkg::CFG_MAGIC, 64'(mag));
    write_reg(kcrd_pkg::CFG_VERSION, 64'(ver));
    write_reg(CFG_UNUSED_FIRST + kcrd_pkg::CfgIdxW'($urandom_range(0, 2)),
              {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_record(input rec_kind_e kind);
    logic [7:0]         plain [$];
    logic [7:0]         rec [$];
    logic [31:0]        size_w;
    logic [31:0]        crc_w;
    logic [31:0]        magic_w;
    logic [31:0]        version_w;
    int                 nbytes;
    int                 pick;
    int                 split;
    bit                 huge;
    kcrd_pkg::in_item_t it;
    split = -1;
    huge  = 1'b0;
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(1, 24)) rec.insert(rec.size(), 8'($urandom));
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 14) nbytes = $urandom_range(0, 16);
      else if (pick < 18) nbytes = $urandom_range(17, 64);
      else begin
        nbytes = $urandom_range(4, 20);
        huge = 1'b1;
      end
      repeat (nbytes) plain.insert(plain.size(), 8'($urandom));
      size_w = huge ? ($urandom | 32'h0000_0100) : 32'(nbytes);
      crc_w = kcrd_pkg::CrcInit;
      foreach (plain[i]) crc_w = crc_next(crc_w, plain[i]);
      crc_w = ~crc_w;
      if (!huge) for (int i = 0; i < 4; i++) plain.insert(plain.size(), crc_w[8*i +: 8]);
      magic_w   = want_magic;
      version_w = want_version;
      if (kind == REC_BAD_MAGIC) magic_w = magic_w ^ (32'd1 << $urandom_range(0, 31));
      if (kind == REC_BAD_VERSION) version_w = version_w ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), magic_w[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), version_w[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), size_w[8*i +: 8]);
      foreach (plain[i]) rec.insert(rec.size(), plain[i] ^ key_at(4'(i % key_span())));
      if (kind == REC_BAD_CRC) begin
        pick = kcrd_pkg::HdrBytes + $urandom_range(0, rec.size() - kcrd_pkg::HdrBytes - 1);
        rec[pick] = rec[pick] ^ (8'd1 << $urandom_range(0, 7));
      end
      if (kind == REC_TRUNCATED) begin
        nbytes = $urandom_range(1, rec.size() - 1);
        while (rec.size() > nbytes) void'(rec.pop_back());
      end
      if (kind == REC_GOOD && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) rec.insert(rec.size(), 8'($urandom));
      if (kind == REC_GOOD && rec.size() > kcrd_pkg::MinRecord + 2 &&
          $urandom_range(0, 7) == 0)
        split = kcrd_pkg::HdrBytes + 1;
    end
    foreach (rec[i]) begin
      it.data_byte  = rec[i];
      it.final_byte = (i == rec.size() - 1);
      send_byte(it, 1'b0, kcrd_pkg::ST_OK);
      if (i == split) begin
        // change the key length mid-record, once the block has gone idle
        wait_idle();
        write_reg(kcrd_pkg::CFG_KEY_LEN, 64'($urandom_range(0, 31)));
        cfg_we_i <= 1'b0;
      end
    end
    records_sent++;
  endtask

  always @(posedge clk_i) begin : result_check
    kcrd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (want.result_kind == kcrd_pkg::KIND_STATUS) status_seen[want.record_status]++;
        check_field("result_kind", 32'(want.result_kind), 32'(out_data_o.result_kind));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_data_o.payload_byte));
        check_field("payload_offset", want.payload_offset, out_data_o.payload_offset);
        check_field("record_status", 32'(want.record_status), 32'(out_data_o.record_status));
        check_field("end_of_run", 32'(want.end_of_run), 32'(out_data_o.end_of_run));
      end
    end
  end

  initial begin : result_sink
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // hold off long enough for the block to fill and stall its input
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (idle >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle, expected_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    kcrd_pkg::in_item_t it;
    rec_kind_e          kind;
    int                 phase;
    int                 pick;
    int                 rand_start;
    bit                 hold_done;
    phase     = 0;
    hold_done = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DirRows); i++) begin
      it.data_byte  = DirRows[i].data_byte;
      it.final_byte = DirRows[i].final_byte;
      send_byte(it, DirRows[i].fixed, DirRows[i].status);
    end
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomBytes) begin
      if (records_sent % RecsPerPhase == 0) begin
        wait_idle();
        configure_phase(phase);
        phase++;
      end
      if (!hold_done && bytes_sent - rand_start > HoldFrom) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (bytes_sent - rand_start > CalmFrom) calm = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 11) kind = REC_GOOD;
      else if (pick < 12) kind = REC_BAD_MAGIC;
      else if (pick < 13) kind = REC_BAD_VERSION;
      else if (pick < 15) kind = REC_TRUNCATED;
      else if (pick < 17) kind = REC_BAD_CRC;
      else kind = REC_NOISE;
      send_record(kind);
    end
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Run covered %0d bytes, %0d random records over %0d register settings, %0d results",
             bytes_sent, records_sent, phase, results_seen);
    $display("Statuses: ok %0d, short header %0d, bad magic %0d, bad version %0d, %s %0d, %s %0d",
             status_seen[kcrd_pkg::ST_OK], status_seen[kcrd_pkg::ST_SHORT_HEADER],
             status_seen[kcrd_pkg::ST_BAD_MAGIC], status_seen[kcrd_pkg::ST_BAD_VERSION],
             "short payload", status_seen[kcrd_pkg::ST_SHORT_DATA],
             "crc error", status_seen[kcrd_pkg::ST_CRC_MISMATCH]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
src/kcrd_pkg.sv
src/kcrd_out_queue.sv
src/keyed_crc_record_deframer_top.sv
src/kcrd_checker.sv
tb/keyed_crc_record_deframer_top_tb.sv
